/* rtl/core/psu_pkg.sv */
// Shared types and constants for the PNG scanline unfilter.
// Used by psu_predict, png_scanline_unfilter and the testbench; depends on nothing.
package psu_pkg;

	// Register widths and defaults
	localparam int ROW_BYTES_W       = 15;
	localparam int BPP_W             = 4;
	localparam int CFG_W             = 15;
	localparam int CFG_AW            = 1;
	localparam int MAX_ROW_BYTES_DEF = 16384;
	localparam int MAX_PIXEL_BYTES   = 8;

	// Result field widths
	localparam int INDEX_W = 14;

	// Short history of the current row and of the row above, indexed mod 8
	localparam int HIST_DEPTH = 8;
	localparam int HIST_W     = 3;

	// Configuration register indexes
	localparam logic [CFG_AW-1:0] CFG_ROW_BYTES = 1'b0;
	localparam logic [CFG_AW-1:0] CFG_BPP       = 1'b1;

	// Filter type codes as carried in the first byte of a scanline
	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filter_t;

	// Operands for one byte reconstruction
	typedef struct packed {
		filter_t    filt;
		logic [7:0] cur;
		logic [7:0] left;
		logic [7:0] up;
		logic [7:0] up_left;
	} pred_in_t;

endpackage

/* rtl/core/png_scanline_unfilter.sv */
// PNG scanline unfilter: filter byte decode, byte reconstruction, line store.
// Depends on psu_pkg, psu_ram (line store) and psu_predict (filter rules).
//
//  channel  dir  fields                                   handshake
//  s_*      in   tdata: data_byte; tuser: image_start     tvalid/tready
//  m_*      out  tdata: pixel_byte, byte_index; tlast:    tvalid/tready
//                row_end; tuser: bad_filter
//  cfg_*    in   cfg_addr: register index; cfg_data       cfg_we, no wait
//
// One byte is taken every cycle while the output is not stalled. The accepting edge
// loads stage 1 and the line store read data; the predictor and add follow, and the
// result register takes it from stage 1 when the output can accept it. The
// left-neighbor path from the history registers via Paeth select is combinational.
// Reset is asynchronous, active low; the line store is not cleared. A stalled
// output holds the result register, then stage 1, then s_tready drops.
module png_scanline_unfilter #(
	parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] data_byte
	input  logic                        s_tuser,   // [0] image_start

	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,   // [7:0] pixel_byte, [21:8] byte_index
	output logic                        m_tlast,   // row_end
	output logic                        m_tuser,   // [0] bad_filter

	input  logic                        cfg_we,
	input  logic [psu_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [psu_pkg::CFG_W-1:0]   cfg_data
);

	localparam int AW = $clog2(MAX_ROW_BYTES);
	// Wide enough for the row length register and for MAX_ROW_BYTES itself
	localparam int CW = (AW + 1 > psu_pkg::ROW_BYTES_W) ? AW + 1 : psu_pkg::ROW_BYTES_W;
	localparam int HW = psu_pkg::HIST_W;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [psu_pkg::ROW_BYTES_W-1:0] row_bytes_q;
	logic [psu_pkg::BPP_W-1:0]       bpp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= psu_pkg::ROW_BYTES_W'(1);
			bpp_q       <= psu_pkg::BPP_W'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				psu_pkg::CFG_ROW_BYTES: row_bytes_q <= cfg_data[psu_pkg::ROW_BYTES_W-1:0];
				psu_pkg::CFG_BPP:       bpp_q       <= cfg_data[psu_pkg::BPP_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp both registers into their legal ranges
	logic [CW-1:0]             rb_ext, rb_eff;
	logic [psu_pkg::BPP_W-1:0] bpp_eff;

	always_comb begin
		rb_ext = CW'(row_bytes_q);
		if (rb_ext == '0) begin
			rb_eff = CW'(1);
		end else if (rb_ext > CW'(MAX_ROW_BYTES)) begin
			rb_eff = CW'(MAX_ROW_BYTES);
		end else begin
			rb_eff = rb_ext;
		end

		if (bpp_q == '0) begin
			bpp_eff = psu_pkg::BPP_W'(1);
		end else if (bpp_q > psu_pkg::BPP_W'(psu_pkg::MAX_PIXEL_BYTES)) begin
			bpp_eff = psu_pkg::BPP_W'(psu_pkg::MAX_PIXEL_BYTES);
		end else begin
			bpp_eff = bpp_q;
		end
	end

	// ---------------------------------------------------------------
	// Front end: row sequencing at accept time
	// ---------------------------------------------------------------
	logic            halted_q;   // discard input until next image start
	logic            expect_q;   // next byte is a filter byte
	logic            first_q;    // current row is the first of the image
	psu_pkg::filter_t filt_q;
	logic [AW-1:0]   idx_q;      // index of the next data byte in the row

	logic acc, start, halted_n, want_filt, last_now, is_data, is_err;

	assign acc       = s_tvalid && s_tready;
	assign start     = s_tuser;
	assign halted_n  = halted_q && !start;
	assign want_filt = expect_q || start;
	assign last_now  = (CW'(idx_q) + CW'(1)) >= rb_eff;
	assign is_data   = acc && !halted_n && !want_filt;
	assign is_err    = acc && !halted_n && want_filt
		&& (s_tdata > 8'(psu_pkg::FILT_PAETH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
			expect_q <= 1'b1;
			first_q  <= 1'b1;
			filt_q   <= psu_pkg::FILT_NONE;
			idx_q    <= '0;
		end else if (acc && !halted_n) begin
			if (want_filt) begin
				// Image start abandons any partial row and clears a halt
				if (start) begin
					first_q <= 1'b1;
				end
				if (s_tdata > 8'(psu_pkg::FILT_PAETH)) begin
					halted_q <= 1'b1;
					expect_q <= 1'b1;
				end else begin
					halted_q <= 1'b0;
					filt_q   <= psu_pkg::filter_t'(s_tdata[2:0]);
					expect_q <= 1'b0;
					idx_q    <= '0;
				end
			end else if (last_now) begin
				expect_q <= 1'b1;
				first_q  <= 1'b0;
			end else begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: line store read data arrives, reconstruct the byte
	// ---------------------------------------------------------------
	logic             valid_s1;
	logic             err_s1;
	logic [7:0]       byte_s1;
	logic [AW-1:0]    idx_s1;
	psu_pkg::filter_t filt_s1;
	logic             first_s1;
	logic             last_s1;

	logic out_valid_q;
	logic s2_take, s1_fire;

	assign s2_take  = !out_valid_q || m_tready;
	assign s1_fire  = valid_s1 && s2_take;
	assign s_tready = !valid_s1 || s2_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= is_data || is_err;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && (is_data || is_err)) begin
			err_s1   <= is_err;
			byte_s1  <= s_tdata;
			idx_s1   <= idx_q;
			filt_s1  <= filt_q;
			first_s1 <= first_q;
			last_s1  <= last_now;
		end
	end

	// Line store: read at accept of a data byte, write back when it leaves stage 1
	logic          ram_we, ram_re;
	logic [7:0]    ram_rdata;
	logic [7:0]    pix;

	assign ram_re = is_data;
	assign ram_we = s1_fire && !err_s1;

	psu_ram #(
		.WIDTH (8),
		.DEPTH (MAX_ROW_BYTES)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (pix),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// Last bytes of this row and of the row above, slot = index mod 8
	logic [7:0] hist_out_q   [psu_pkg::HIST_DEPTH];
	logic [7:0] hist_above_q [psu_pkg::HIST_DEPTH];

	logic              has_left;
	logic [HW-1:0]     left_slot;
	logic [HW-1:0]     cur_slot;
	logic [7:0]        up_byte;
	psu_pkg::pred_in_t op;

	always_comb begin
		has_left   = AW'(bpp_eff) <= idx_s1;
		left_slot  = idx_s1[HW-1:0] - bpp_eff[HW-1:0];
		cur_slot   = idx_s1[HW-1:0];
		up_byte    = first_s1 ? 8'd0 : ram_rdata;
		op.filt    = filt_s1;
		op.cur     = byte_s1;
		op.left    = has_left ? hist_out_q[left_slot] : 8'd0;
		op.up      = up_byte;
		op.up_left = (has_left && !first_s1) ? hist_above_q[left_slot] : 8'd0;
	end

	psu_predict u_predict (
		.op  (op),
		.pix (pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < psu_pkg::HIST_DEPTH; k++) begin
				hist_out_q[k]   <= 8'd0;
				hist_above_q[k] <= 8'd0;
			end
		end else if (ram_we) begin
			hist_out_q[cur_slot]   <= pix;
			hist_above_q[cur_slot] <= up_byte;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: result register
	// ---------------------------------------------------------------
	logic [7:0]                  pixel_q;
	logic [psu_pkg::INDEX_W-1:0] index_q;
	logic                        row_end_q;
	logic                        bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_take) begin
			out_valid_q <= valid_s1;
		end
	end

	// Error result carries zeros in every other field
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			pixel_q   <= err_s1 ? 8'd0 : pix;
			index_q   <= err_s1 ? '0 : psu_pkg::INDEX_W'(idx_s1);
			row_end_q <= err_s1 ? 1'b0 : last_s1;
			bad_q     <= err_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, index_q, pixel_q};
	assign m_tlast  = row_end_q;
	assign m_tuser  = bad_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_err_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0 && !m_tlast))
		else $error("error result carries nonzero fields");

	a_no_store_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re && idx_s1 == idx_q))
		else $error("line store read and write hit the same entry");

	a_halt_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && halted_q && !start) |=> !valid_s1)
		else $error("byte taken while halted produced work");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with stage 1 empty");

endmodule

/* rtl/core/psu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module psu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/psu_predict.sv */
// Filter predictor and byte reconstruction (None, Sub, Up, Average, Paeth).
// Depends on psu_pkg for filter_t and pred_in_t.
module psu_predict (
	input  psu_pkg::pred_in_t op,
	output logic [7:0]        pix
);

	logic [8:0]        avg_sum;
	logic signed [9:0] pa_s, pb_s, pc_s;
	logic [9:0]        pa, pb, pc;
	logic [7:0]        paeth;
	logic [7:0]        pred;

	always_comb begin
		avg_sum = {1'b0, op.left} + {1'b0, op.up};

		// p = a + b - c; distances to a, b, c without forming p
		pa_s = signed'({2'b00, op.up}) - signed'({2'b00, op.up_left});
		pb_s = signed'({2'b00, op.left}) - signed'({2'b00, op.up_left});
		pc_s = signed'({2'b00, op.left}) + signed'({2'b00, op.up})
			- (signed'({2'b00, op.up_left}) <<< 1);
		pa = (pa_s < 0) ? -pa_s : pa_s;
		pb = (pb_s < 0) ? -pb_s : pb_s;
		pc = (pc_s < 0) ? -pc_s : pc_s;

		if (pa <= pb && pa <= pc) begin
			paeth = op.left;
		end else if (pb <= pc) begin
			paeth = op.up;
		end else begin
			paeth = op.up_left;
		end

		case (op.filt)
			psu_pkg::FILT_SUB:   pred = op.left;
			psu_pkg::FILT_UP:    pred = op.up;
			psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
			psu_pkg::FILT_PAETH: pred = paeth;
			default:             pred = 8'd0;
		endcase

		pix = op.cur + pred;
	end

endmodule

/* tb/tb_png_scanline_unfilter.sv */
// Self-checking testbench for png_scanline_unfilter: directed and random streams.
// Depends on psu_pkg for register indexes, widths and filter codes; needs only the RTL.
// Expected bytes come from a behavioral line-store model kept inside this module.
module tb_png_scanline_unfilter;
	import psu_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 7;
	localparam int RANDOM_ITEMS  = 600;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 6;
	localparam int MAX_PRINTED   = 40;
	localparam int RUN_LIMIT     = 10_000_000;

	// Filter byte values that are not filter codes
	localparam logic [7:0] FILT_BYTE_FIRST_BAD = 8'd5;
	localparam logic [7:0] FILT_BYTE_TOP       = 8'hFF;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	typedef struct packed {
		logic [7:0]         pixel_byte;
		logic [INDEX_W-1:0] byte_index;
		logic               row_end;
		logic               bad_filter;
	} pixel_result_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata  = '0;
	logic              s_tuser  = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [23:0]       m_tdata;
	logic              m_tlast;
	logic              m_tuser;
	logic              cfg_we   = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]  cfg_data = '0;

	png_scanline_unfilter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------
	// Unfilter model: register copies, line store and short histories
	// ------------------------------------------------------------------
	logic [ROW_BYTES_W-1:0] cfg_row_bytes = ROW_BYTES_W'(1);
	logic [BPP_W-1:0]       cfg_bpp       = BPP_W'(1);

	bit [7:0]  line_above [MAX_ROW_BYTES_DEF];
	bit [7:0]  hist_out   [HIST_DEPTH];
	bit [7:0]  hist_above [HIST_DEPTH];
	int        row_pos    = 0;      // 0: filter byte next, else 1 + data index
	filter_t   cur_filter = FILT_NONE;
	bit        first_row  = 1'b1;
	bit        halted     = 1'b0;
	int        sent_bytes = 0;      // accepted bytes, discarded ones included

	pixel_result_t expected_pixels[$];

	int mismatch_count = 0;
	int result_count   = 0;

	// Sender pacing and receiver stall control
	bit       tx_gaps    = 1'b1;
	int       burst_left = 0;
	rx_mode_t rx_mode    = RX_ALWAYS;
	logic     rx_hold    = 1'b0;
	int       rx_tick    = 0;
	event     hold_off_ev;

	function automatic int eff_row_len();
		if (cfg_row_bytes == 0) return 1;
		if (cfg_row_bytes > MAX_ROW_BYTES_DEF) return MAX_ROW_BYTES_DEF;
		return int'(cfg_row_bytes);
	endfunction

	function automatic logic [7:0] paeth_select(input logic [7:0] a, b, c);
		int p, pa, pb, pc;
		p  = int'(a) + int'(b) - int'(c);
		pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
		pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
		pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
		if (pa <= pb && pa <= pc) return a;
		if (pb <= pc) return b;
		return c;
	endfunction

	// Advance the model by one accepted byte; queue the byte it should produce
	task automatic reconstruct_byte(input logic [7:0] din, input logic img_start);
		int            bpp, idx;
		logic [7:0]    a, b, c, pred, val;
		pixel_result_t r;
		bpp = (cfg_bpp == 0) ? 1 : (cfg_bpp > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : int'(cfg_bpp);
		// Image start wins over everything: drop any partial row, clear the halt
		if (img_start) begin
			halted    = 1'b0;
			first_row = 1'b1;
			row_pos   = 0;
		end
		if (halted) return;
		r = '0;
		if (row_pos == 0) begin
			if (din > FILT_PAETH) begin
				// Unknown filter: one error transaction, then discard until image start
				halted       = 1'b1;
				r.bad_filter = 1'b1;
				expected_pixels.push_back(r);
			end else begin
				cur_filter = filter_t'(din[2:0]);
				row_pos    = 1;
			end
			return;
		end
		idx = row_pos - 1;
		if (idx >= MAX_ROW_BYTES_DEF) idx = MAX_ROW_BYTES_DEF - 1;
		// Left and upper-left are zero before the row start; above is zero on row one
		a = (idx >= bpp) ? hist_out[(idx - bpp) % HIST_DEPTH] : 8'd0;
		b = first_row ? 8'd0 : line_above[idx];
		c = (idx >= bpp && !first_row) ? hist_above[(idx - bpp) % HIST_DEPTH] : 8'd0;
		hist_above[idx % HIST_DEPTH] = b;
		case (cur_filter)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
			FILT_PAETH: pred = paeth_select(a, b, c);
			default:    pred = 8'd0;
		endcase
		val = din + pred;
		line_above[idx]            = val;
		hist_out[idx % HIST_DEPTH] = val;
		r.pixel_byte = val;
		r.byte_index = INDEX_W'(idx);
		// A row closes at its length, or at once if the length shrank below the index
		r.row_end    = (idx + 1 >= eff_row_len());
		if (r.row_end) begin
			row_pos   = 0;
			first_row = 1'b0;
		end else begin
			row_pos = idx + 2;
		end
		expected_pixels.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one byte, hold it until the transaction completes, then pace the burst
	task automatic send_byte(input logic [7:0] din, input logic img_start);
		s_tvalid <= 1'b1;
		s_tdata  <= din;
		s_tuser  <= img_start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_bytes++;
		reconstruct_byte(din, img_start);
		if (tx_gaps) begin
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Filter byte followed by n data bytes, biased toward the byte extremes
	task automatic send_row(input logic [7:0] filt, input logic img_start, input int n);
		logic [7:0] d;
		send_byte(filt, img_start);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0:       d = 8'h00;
				1:       d = 8'hFF;
				default: d = 8'($urandom);
			endcase
			send_byte(d, 1'b0);
		end
	endtask

	// Drop valid, wait for every queued byte, then cover filter bytes still in flight
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Registers change only while the block is idle
	task automatic write_reg(input logic [CFG_AW-1:0] addr, input int val);
		cfg_we   <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == CFG_ROW_BYTES) cfg_row_bytes = ROW_BYTES_W'(val);
		else cfg_bpp = BPP_W'(val);
		@(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
				$time, result_count, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Receiver: stall pattern of its own, plus a long hold-off on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_hold) begin
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: m_tready <= 1'b1;
				RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
				default:   m_tready <= ((rx_tick % 7) < 4);
			endcase
		end
	end

	// Hold the output off long enough for the block to fill and stall its input
	always begin
		@(hold_off_ev);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// ------------------------------------------------------------------
	// Result checker: compare each output transaction with the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		pixel_result_t got, want;
		if (m_tvalid && m_tready) begin
			got.pixel_byte = m_tdata[7:0];
			got.byte_index = m_tdata[8 +: INDEX_W];
			got.row_end    = m_tlast;
			got.bad_filter = m_tuser;
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected transaction, pixel_byte", got.pixel_byte, 0);
			end else begin
				want = expected_pixels.pop_front();
				if (got.pixel_byte !== want.pixel_byte)
					report_mismatch("pixel_byte", got.pixel_byte, want.pixel_byte);
				if (got.byte_index !== want.byte_index)
					report_mismatch("byte_index", got.byte_index, want.byte_index);
				if (got.row_end !== want.row_end)
					report_mismatch("row_end", got.row_end, want.row_end);
				if (got.bad_filter !== want.bad_filter)
					report_mismatch("bad_filter", got.bad_filter, want.bad_filter);
			end
			result_count++;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// One short row per filter rule, data mostly at the byte extremes
	task automatic test_filter_rules();
		write_reg(CFG_ROW_BYTES, 2);
		write_reg(CFG_BPP, 1);
		send_byte(FILT_NONE, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(FILT_SUB, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(FILT_UP, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(FILT_AVG, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(FILT_PAETH, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
	endtask

	// Zero-valued registers clamp to one; unknown filters halt until image start
	task automatic test_bad_filter_and_clamps();
		wait_drained();
		write_reg(CFG_ROW_BYTES, 0);
		write_reg(CFG_BPP, 0);
		send_byte(FILT_BYTE_FIRST_BAD, 1'b1);
		send_byte(8'h33, 1'b0);          // discarded while halted
		send_byte(FILT_NONE, 1'b0);      // a valid code is discarded too
		send_byte(FILT_BYTE_TOP, 1'b1);
		send_byte(FILT_SUB, 1'b1);
		send_byte(8'h05, 1'b0);
		send_byte(FILT_UP, 1'b0);
		send_byte(8'h07, 1'b0);
		send_byte(FILT_AVG, 1'b0);
		send_byte(FILT_PAETH, 1'b1);     // image start right after a filter byte
		send_byte(8'h09, 1'b0);
	endtask

	// Keep offering bytes while the receiver holds off for a long stretch
	task automatic test_backpressure();
		wait_drained();
		write_reg(CFG_ROW_BYTES, 64);
		write_reg(CFG_BPP, 3);
		rx_mode <= RX_ALWAYS;
		tx_gaps = 1'b0;
		-> hold_off_ev;
		send_row(FILT_PAETH, 1'b1, 64);
		send_row(FILT_SUB, 1'b0, 64);
		send_row(FILT_PAETH, 1'b0, 64);
		send_row(FILT_AVG, 1'b0, 64);
		tx_gaps = 1'b1;
	endtask

	// Oversized registers clamp to the maximum, so a long row stays open; then shrink it
	task automatic test_max_row_and_shrink();
		wait_drained();
		write_reg(CFG_ROW_BYTES, (1 << ROW_BYTES_W) - 1);
		write_reg(CFG_BPP, (1 << BPP_W) - 1);
		rx_mode <= RX_RANDOM;
		send_row(FILT_PAETH, 1'b1, 300);
		wait_drained();
		// Index 300 already passes the new length, so this byte closes the row
		write_reg(CFG_ROW_BYTES, 100);
		send_byte(8'($urandom), 1'b0);
		send_row(FILT_AVG, 1'b0, 100);
		send_row(FILT_PAETH, 1'b0, 100);
	endtask

	// Phases of random settings and images; mostly well-formed rows, some broken
	task automatic test_random_streams();
		int base, rows, kind, rb;
		base = sent_bytes;
		while (sent_bytes - base < RANDOM_ITEMS) begin
			wait_drained();
			kind = $urandom_range(0, 19);
			if (kind < 2) rb = 0;
			else if (kind < 4) rb = 1;
			else if (kind < 6) rb = $urandom_range(40, 160);
			else rb = $urandom_range(2, 24);
			write_reg(CFG_ROW_BYTES, rb);
			write_reg(CFG_BPP, $urandom_range(0, (1 << BPP_W) - 1));
			rx_mode <= rx_mode_t'($urandom_range(RX_ALWAYS, RX_PATTERN));
			tx_gaps = ($urandom_range(0, 3) != 0);
			// Every image opens with image start, so no row above is read unwritten
			repeat ($urandom_range(1, 3)) begin
				rows = $urandom_range(1, 5);
				for (int r = 0; r < rows; r++) begin
					if (sent_bytes - base >= RANDOM_ITEMS) break;
					kind = $urandom_range(0, 99);
					if (kind < 4) begin
						send_byte(8'($urandom_range(FILT_BYTE_FIRST_BAD, FILT_BYTE_TOP)),
							r == 0);
						repeat ($urandom_range(0, 5)) send_byte(8'($urandom), 1'b0);
						break;
					end
					if (kind < 8) begin
						// Partial row, abandoned by the next image start
						send_row(8'($urandom_range(FILT_NONE, FILT_PAETH)), r == 0,
							$urandom_range(0, eff_row_len() - 1));
						break;
					end
					send_row(8'($urandom_range(FILT_NONE, FILT_PAETH)), r == 0,
						eff_row_len());
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_filter_rules();
		test_bad_filter_and_clamps();
		test_backpressure();
		test_max_row_and_shrink();
		test_random_streams();
		wait_drained();
		if (mismatch_count == 0) begin
			$display("png_scanline_unfilter test passed");
		end else begin
			$display("png_scanline_unfilter test failed");
		end
		$finish;
	end

	// Watchdog: end a hung run
	initial begin
		#RUN_LIMIT;
		$display("png_scanline_unfilter test failed");
		$finish;
	end

endmodule

/* files.f */
rtl/core/psu_pkg.sv
rtl/core/psu_ram.sv
rtl/core/psu_predict.sv
rtl/core/png_scanline_unfilter.sv
tb/tb_png_scanline_unfilter.sv
